// File: design/slc_pkg.sv
// Types and constants shared by the scalar literal classifier.
`timescale 1ns / 1ps

package slc_pkg;

   // Result kind codes
   typedef enum logic [2:0] {
      KIND_EMPTY   = 3'd0,
      KIND_INVALID = 3'd1,
      KIND_CHAR    = 3'd2,
      KIND_INT     = 3'd3,
      KIND_FLOAT   = 3'd4,
      KIND_DOUBLE  = 3'd5
   } kind_type;

   localparam int unsigned WORD_COUNT = 8;
   localparam int unsigned WORD_SLOTS = 8;

   // Special words, padded with zero bytes; entries 0..3 are float words,
   // 4..7 double words.
   localparam logic [7:0] WORD_TEXT [0:WORD_COUNT-1][0:WORD_SLOTS-1] = '{
      '{"-", "i", "n", "f", "f", 8'h00, 8'h00, 8'h00},
      '{"+", "i", "n", "f", "f", 8'h00, 8'h00, 8'h00},
      '{"i", "n", "f", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "a", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"-", "i", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"+", "i", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "n", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "a", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [2:0] WORD_LEN [0:WORD_COUNT-1] = '{
      3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3, 3'd3
   };

   localparam logic [7:0] CHAR_DOT   = ".";
   localparam logic [7:0] CHAR_F     = "f";
   localparam logic [7:0] CHAR_PLUS  = "+";
   localparam logic [7:0] CHAR_MINUS = "-";
   localparam logic [7:0] CHAR_ZERO  = "0";
   localparam logic [7:0] CHAR_NINE  = "9";
   localparam logic [7:0] PRINT_LO   = 8'd32;
   localparam logic [7:0] PRINT_HI   = 8'd126;
   localparam logic [2:0] COUNT_MAX  = 3'd7;

   // Largest magnitude accepted (negative limit of a signed 32-bit int)
   localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

   // Running parse state of one literal
   typedef struct packed {
      logic [2:0]  char_count;
      logic [7:0]  first_char;
      logic        sign_present;
      logic        negative;
      logic        dot_seen;
      logic        digit_seen;
      logic        bad_form;
      logic        suffix_f_seen;
      logic [31:0] magnitude;
      logic        int_overflow;
      logic [7:0]  word_mask;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      char_count:    3'd0,
      first_char:    8'h00,
      sign_present:  1'b0,
      negative:      1'b0,
      dot_seen:      1'b0,
      digit_seen:    1'b0,
      bad_form:      1'b0,
      suffix_f_seen: 1'b0,
      magnitude:     32'd0,
      int_overflow:  1'b0,
      word_mask:     8'hFF
   };

endpackage

// File: design/scalar_literal_classifier.sv
// Scalar literal classifier: one character word in, one kind/value word per literal.
// A result word is formed as the literal's last word passes from the input register
// through the parse/classify logic into the result register.
// Throughput: one character word per cycle; the result register has its own slot,
// so parsing carries on while a result waits; only the next closing word stalls.
// Reset (synchronous, active high) empties both registers and clears the parse state.
`timescale 1ns / 1ps

module scalar_literal_classifier
   import slc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // character words
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_no_char,
   input  logic               req_is_last,
   // result words
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic signed [31:0] rsp_value,
   output logic               rsp_displayable
);

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       in_none_ff;
   logic       in_last_ff;

   logic       rsp_valid_ff;
   kind_type   rsp_kind_ff;
   logic [31:0] rsp_value_ff;
   logic       rsp_disp_ff;

   parse_state_type state_ff;
   parse_state_type state_in;

   // The held word moves on unless it closes a literal and the result slot is full.
   logic s1_move;
   assign s1_move   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_none_ff <= req_no_char;
         in_last_ff <= req_is_last;
      end
   end

   // ---------------------------------------------------------------
   // Parse step: fold one character into the running state
   // ---------------------------------------------------------------
   logic [2:0]  pos;
   logic        is_digit;
   logic [35:0] mag_next;

   assign pos      = state_ff.char_count;
   assign is_digit = (in_char_ff >= CHAR_ZERO) && (in_char_ff <= CHAR_NINE);
   // magnitude * 10 + digit, as shifts and adds
   assign mag_next = {1'b0, state_ff.magnitude, 3'b000}
                   + {3'b000, state_ff.magnitude, 1'b0}
                   + {32'd0, in_char_ff[3:0]};

   always_comb begin
      state_in = state_ff;
      if (!in_none_ff) begin
         // knock out every special word that this character breaks
         for (int w = 0; w < WORD_COUNT; w++) begin
            if (pos >= WORD_LEN[w] || WORD_TEXT[w][pos] != in_char_ff) begin
               state_in.word_mask[w] = 1'b0;
            end
         end
         if (pos == 3'd0) begin
            state_in.first_char = in_char_ff;
         end
         priority if (state_ff.suffix_f_seen) begin
            state_in.bad_form = 1'b1;       // nothing may follow the f
         end else if (is_digit) begin
            state_in.digit_seen = 1'b1;
            if (!state_ff.int_overflow) begin
               if (mag_next > MAG_LIMIT) begin
                  state_in.int_overflow = 1'b1;
               end else begin
                  state_in.magnitude = mag_next[31:0];
               end
            end
         end else if (in_char_ff == CHAR_DOT) begin
            if (state_ff.dot_seen) begin
               state_in.bad_form = 1'b1;
            end
            state_in.dot_seen = 1'b1;
         end else if (in_char_ff == CHAR_PLUS || in_char_ff == CHAR_MINUS) begin
            if (pos == 3'd0) begin
               state_in.sign_present = 1'b1;
               state_in.negative     = (in_char_ff == CHAR_MINUS);
            end else begin
               state_in.bad_form = 1'b1;
            end
         end else if (in_char_ff == CHAR_F) begin
            state_in.suffix_f_seen = 1'b1;
         end else begin
            state_in.bad_form = 1'b1;
         end
         if (pos < COUNT_MAX) begin
            state_in.char_count = pos + 3'd1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Classification of the state after this character
   // ---------------------------------------------------------------
   logic [WORD_COUNT-1:0] len_hit;
   logic        num_core;
   logic        word_float;
   logic        word_double;
   logic        int_ok;
   kind_type    kind_in;
   logic [31:0] value_in;
   logic        disp_in;

   always_comb begin
      for (int w = 0; w < WORD_COUNT; w++) begin
         len_hit[w] = state_in.word_mask[w] && (WORD_LEN[w] == state_in.char_count);
      end
   end

   assign num_core    = !state_in.bad_form && state_in.digit_seen;
   assign word_float  = |len_hit[3:0];
   assign word_double = |len_hit[7:4];
   // magnitude never exceeds 2^31; only a positive 2^31 falls out of range
   assign int_ok      = num_core && !state_in.dot_seen && !state_in.suffix_f_seen
                      && !state_in.int_overflow
                      && (state_in.negative || !state_in.magnitude[31]);

   always_comb begin
      kind_in  = KIND_INVALID;
      value_in = 32'd0;
      priority if (state_in.char_count == 3'd0) begin
         kind_in = KIND_EMPTY;
      end else if (int_ok) begin
         kind_in  = KIND_INT;
         value_in = state_in.negative ? (32'd0 - state_in.magnitude)
                                      : state_in.magnitude;
      end else if (state_in.char_count == 3'd1 && state_in.first_char >= PRINT_LO
                   && state_in.first_char <= PRINT_HI) begin
         kind_in  = KIND_CHAR;
         value_in = {24'd0, state_in.first_char};
      end else if (word_float
                   || (num_core && state_in.dot_seen && state_in.suffix_f_seen)) begin
         kind_in = KIND_FLOAT;
      end else if (word_double
                   || (num_core && state_in.dot_seen && !state_in.suffix_f_seen)) begin
         kind_in = KIND_DOUBLE;
      end else begin
         kind_in = KIND_INVALID;
      end
   end

   assign disp_in = (kind_in == KIND_INT || kind_in == KIND_CHAR)
                  && (value_in >= {24'd0, PRINT_LO}) && (value_in <= {24'd0, PRINT_HI});

   // ---------------------------------------------------------------
   // Parse state and result register
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (s1_move) begin
         state_ff <= in_last_ff ? STATE_RESET : state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && in_last_ff) begin
         rsp_kind_ff  <= kind_in;
         rsp_value_ff <= value_in;
         rsp_disp_ff  <= disp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_value       = $signed(rsp_value_ff);
   assign rsp_displayable = rsp_disp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
`ifndef SYNTH
   // only int and char results can be flagged printable
   a_disp_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_disp_ff |-> (rsp_kind_ff == KIND_INT || rsp_kind_ff == KIND_CHAR))
      else $error("displayable set on a non int/char result");

   // kinds other than int and char carry a zero value
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_INT && rsp_kind_ff != KIND_CHAR
      |-> rsp_value_ff == 32'd0)
      else $error("non-zero value on a kind without a value");

   // a fresh result only follows a literal's closing word leaving the input register
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(s1_move && in_last_ff))
      else $error("result appeared without a closing word");

   // the parse state starts over after each literal
   a_state_restart: assert property (@(posedge clock) disable iff (reset)
      s1_move && in_last_ff |=> state_ff == STATE_RESET)
      else $error("parse state not cleared after a literal");
`endif

endmodule

// File: dv/slc_score_pkg.sv
// Scoreboard class for the scalar literal classifier: parse predictor and result checks.
`timescale 1ns / 1ps

package slc_score_pkg;
   import slc_pkg::*;

   typedef struct {
      kind_type           kind;
      logic signed [31:0] value;
      logic               disp;
   } verdict_type;

   class literal_scoreboard;
      // float words first, then double words
      string              spell [8] = '{"-inff", "+inff", "inff", "nanf",
                                        "-inf", "+inf", "inf", "nan"};
      logic [2:0]         n_chars;
      logic [7:0]         lead;
      logic               neg;
      logic               dot;
      logic               digits;
      logic               malformed;
      logic               f_tail;
      logic [31:0]        mag;
      logic               ovf;
      logic [7:0]         word_hits;
      verdict_type        due_verdicts [$];
      int                 mismatches = 0;

      function new();
         clear_parse();
      endfunction

      function void clear_parse();
         n_chars   = 3'd0;
         lead      = 8'h00;
         neg       = 1'b0;
         dot       = 1'b0;
         digits    = 1'b0;
         malformed = 1'b0;
         f_tail    = 1'b0;
         mag       = 32'd0;
         ovf       = 1'b0;
         word_hits = 8'hFF;
      endfunction

      function void take_char(logic [7:0] c);
         int          w;
         logic [63:0] grown;
         for (w = 0; w < 8; w++) begin
            if (n_chars >= spell[w].len() || 8'(spell[w][n_chars]) != c)
               word_hits[w] = 1'b0;
         end
         if (n_chars == 3'd0)
            lead = c;
         if (f_tail) begin
            malformed = 1'b1;
         end else if (c >= "0" && c <= "9") begin
            digits = 1'b1;
            if (!ovf) begin
               grown = 64'(mag) * 64'd10 + 64'(c - 8'("0"));
               if (grown > 64'h8000_0000)
                  ovf = 1'b1;
               else
                  mag = grown[31:0];
            end
         end else if (c == ".") begin
            if (dot)
               malformed = 1'b1;
            dot = 1'b1;
         end else if (c == "+" || c == "-") begin
            if (n_chars == 3'd0)
               neg = (c == "-");
            else
               malformed = 1'b1;
         end else if (c == "f") begin
            f_tail = 1'b1;
         end else begin
            malformed = 1'b1;
         end
         if (n_chars != 3'd7)
            n_chars++;
      endfunction

      function bit word_hit(int lo, int hi);
         int w;
         for (w = lo; w < hi; w++) begin
            if (word_hits[w] && spell[w].len() == n_chars)
               return 1'b1;
         end
         return 1'b0;
      endfunction

      function verdict_type judge_literal();
         verdict_type v;
         bit          core;
         core    = !malformed && digits;
         v.kind  = KIND_INVALID;
         v.value = 32'sd0;
         if (n_chars == 3'd0) begin
            v.kind = KIND_EMPTY;
         end else if (core && !dot && !f_tail && !ovf &&
                      (neg ? mag <= 32'h8000_0000 : mag <= 32'h7FFF_FFFF)) begin
            v.kind  = KIND_INT;
            v.value = neg ? 32'(32'd0 - mag) : mag;
         end else if (n_chars == 3'd1 && lead >= 8'd32 && lead <= 8'd126) begin
            v.kind  = KIND_CHAR;
            v.value = {24'd0, lead};
         end else if (word_hit(0, 4) || (core && dot && f_tail)) begin
            v.kind = KIND_FLOAT;
         end else if (word_hit(4, 8) || (core && dot && !f_tail)) begin
            v.kind = KIND_DOUBLE;
         end
         v.disp = (v.kind == KIND_INT || v.kind == KIND_CHAR) &&
                  v.value >= 32 && v.value <= 126;
         return v;
      endfunction

      // One accepted character word.
      function void note_word(logic [7:0] c, logic nc, logic last);
         if (!nc)
            take_char(c);
         if (last) begin
            due_verdicts.push_back(judge_literal());
            clear_parse();
         end
      endfunction

      // One accepted result word.
      function void check_result(logic [2:0] kind, logic signed [31:0] value, logic disp);
         verdict_type e;
         if (due_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d value %0d disp %0d", kind, value, disp);
            return;
         end
         e = due_verdicts.pop_front();
         if (kind !== e.kind || value !== e.value || disp !== e.disp) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected kind %0d value %0d disp %0d, got %0d %0d %0d",
                        e.kind, e.value, e.disp, kind, value, disp);
         end
      endfunction

      function int pending();
         return due_verdicts.size();
      endfunction

      function bit clean();
         return mismatches == 0 && due_verdicts.size() == 0;
      endfunction
   endclass

endpackage

// File: dv/tb_scalar_literal_classifier.sv
// Top-level testbench for the scalar literal classifier.
`timescale 1ns / 1ps

module tb_scalar_literal_classifier;
   import slc_pkg::*;
   import slc_score_pkg::*;

   typedef logic [7:0] octets_type [$];

   localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
   localparam int RANDOM_WORDS = 1700;
   localparam int CALM_FROM    = 1400;  // last stretch runs without idling
   localparam int TAIL_CYCLES  = 10;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_char_code;
   logic               req_no_char;
   logic               req_is_last;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [2:0]         rsp_kind;
   logic signed [31:0] rsp_value;
   logic               rsp_displayable;

   literal_scoreboard  board;
   int                 words_sent  = 0;   // character words, ignored ones excluded
   int                 idle_cycles = 0;
   int                 hold_cycles = 0;   // long receiver hold-off, counted down below
   bit                 tx_gaps     = 1'b0;
   bit                 rx_stall    = 1'b0;
   bit                 sprinkle    = 1'b0; // drop ignored no-char words between characters

   string              pool = "0123456789+-.fina";
   string              word_bank [8] = '{"-inff", "+inff", "inff", "nanf",
                                         "-inf", "+inf", "inf", "nan"};

   scalar_literal_classifier u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_code   (req_char_code),
      .req_no_char     (req_no_char),
      .req_is_last     (req_is_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_displayable (rsp_displayable)
   );

   always #1 clock = ~clock;

   // Result side: every accepted word is checked against the oldest prediction.
   // Sampling at the edge sees pre-edge values, i.e. what the block saw.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_kind, rsp_value, rsp_displayable);
   end

   // Receiver: long hold-off first, then any burst in progress, then fresh random
   // stall bursts. Exactly one assignment to rsp_ready per edge.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (rx_stall && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: the run is declared hung once idle_cycles reaches STALL_LIMIT.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("scalar_literal_classifier verification failed");
         $finish;
      end
   end

   // Offer one character word and wait for it to be taken. Called at a rising
   // edge; returns at the edge that took the word, so the next call may drive
   // straight on without dropping valid.
   task automatic offer(input logic [7:0] c, input logic nc, input logic last);
      int gap;
      if (tx_gaps && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_no_char   <= nc;
      req_is_last   <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(c, nc, last);
      if (!(nc && !last))
         words_sent++;
   endtask

   // A whole literal. With marker_end the literal is closed by a no-char last
   // word rather than by flagging its final character; an empty one always is.
   task automatic send_literal(input octets_type lit, input bit marker_end);
      int i;
      for (i = 0; i < lit.size(); i++) begin
         if (sprinkle && $urandom_range(0, 15) == 0)
            offer(8'($urandom_range(0, 255)), 1'b1, 1'b0);
         offer(lit[i], 1'b0, !marker_end && i == lit.size() - 1);
      end
      if (marker_end || lit.size() == 0)
         offer(8'($urandom_range(0, 255)), 1'b1, 1'b1);
   endtask

   // Stop offering until every predicted result has come back. Always waits on
   // the clock before checking, so valid is never dropped and raised in one step.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   function automatic octets_type text_bytes(input string s);
      octets_type q;
      int         i;
      for (i = 0; i < s.len(); i++)
         q.push_back(s[i]);
      return q;
   endfunction

   function automatic octets_type one_byte(input logic [7:0] c);
      octets_type q;
      q.push_back(c);
      return q;
   endfunction

   function automatic void add_digits(ref octets_type lit, input int n);
      int i;
      for (i = 0; i < n; i++)
         lit.push_back(8'("0" + $urandom_range(0, 9)));
   endfunction

   // Mostly well-formed literals with random content; the rest is noise.
   function automatic octets_type make_literal();
      octets_type lit;
      int         pick;
      int         n;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         // integers, a quarter of them hugging the 32-bit edge
         if ($urandom_range(0, 2) == 0)
            lit.push_back($urandom_range(0, 1) ? "-" : "+");
         if ($urandom_range(0, 3) == 0) begin
            lit = {lit, text_bytes("214748364")};
            lit.push_back(8'("0" + $urandom_range(5, 9)));
            if ($urandom_range(0, 3) == 0)
               add_digits(lit, 1);
         end else begin
            add_digits(lit, $urandom_range(1, 11));
         end
      end else if (pick < 55) begin
         // float / double shapes, with the odd second dot or junk tail
         if ($urandom_range(0, 3) == 0)
            lit.push_back($urandom_range(0, 1) ? "-" : "+");
         add_digits(lit, $urandom_range(0, 4));
         if ($urandom_range(0, 9) != 0)
            lit.push_back(".");
         add_digits(lit, $urandom_range(0, 4));
         if ($urandom_range(0, 9) == 0)
            lit.push_back(".");
         if ($urandom_range(0, 1))
            lit.push_back("f");
         if ($urandom_range(0, 14) == 0)
            lit.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      end else if (pick < 70) begin
         // special words, some of them bent
         lit = text_bytes(word_bank[$urandom_range(0, 7)]);
         case ($urandom_range(0, 5))
            0: lit[$urandom_range(0, lit.size() - 1)] =
                  pool[$urandom_range(0, pool.len() - 1)];
            1: lit.push_back("f");
            2: void'(lit.pop_back());
            default: ;
         endcase
      end else if (pick < 82) begin
         lit.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
         // empty literal
      end else begin
         n = $urandom_range(1, 9);
         repeat (n) begin
            if ($urandom_range(0, 1))
               lit.push_back(pool[$urandom_range(0, pool.len() - 1)]);
            else
               lit.push_back(8'($urandom_range(0, 255)));
         end
      end
      return lit;
   endfunction

   initial begin
      string directed [];
      bit held;
      bit paused;
      directed      = '{"", "0", "-2147483648", "2147483647", "2147483648",
                        "-2147483649", "+42", "99999999999", "a", "~", " ",
                        "1.5f", "-.5", "3.", ".f", "1.2.3", "1f", "1.0ff",
                        "12-3", "-inff", "+inff", "inff", "nanf", "-inf",
                        "+inf", "inf", "nan", "infinity"};
      held          = 1'b0;
      paused        = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = 8'h00;
      req_no_char   = 1'b0;
      req_is_last   = 1'b0;
      board         = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: edges of the int range, single chars, every float/double shape,
      // all eight special words, and a few literals closed by a no-char word.
      tx_gaps  = 1'b1;
      rx_stall = 1'b1;
      offer(8'hA5, 1'b1, 1'b0);           // ignored word ahead of anything
      foreach (directed[i])
         send_literal(text_bytes(directed[i]), i % 5 == 4);
      send_literal(one_byte(8'h00), 1'b0);  // zero byte alone: invalid
      send_literal(one_byte(8'h7F), 1'b0);
      send_literal(one_byte(8'hFF), 1'b1);

      // Random literals. Idling is switched on and off in stretches; midway the
      // receiver holds off long enough to back up the input, and later the
      // sender waits for everything to come home.
      words_sent = 0;
      sprinkle   = 1'b1;
      while (words_sent < RANDOM_WORDS) begin
         if (words_sent >= CALM_FROM) begin
            tx_gaps  = 1'b0;
            rx_stall = 1'b0;
         end else if ($urandom_range(0, 19) == 0) begin
            tx_gaps  = $urandom_range(0, 9) < 7;
            rx_stall = $urandom_range(0, 9) < 7;
         end
         if (!held && words_sent >= 500) begin
            hold_cycles = 80;
            held        = 1'b1;
         end
         if (!paused && words_sent >= 900) begin
            drain();
            paused = 1'b1;
         end
         send_literal(make_literal(), $urandom_range(0, 7) == 0);
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.clean()) begin
         $display("scalar_literal_classifier verification clean");
      end else begin
         $display("scalar_literal_classifier verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/slc_pkg.sv
design/scalar_literal_classifier.sv
dv/slc_score_pkg.sv
dv/tb_scalar_literal_classifier.sv
